// ----- design/mrm_pkg.sv -----
// Shared types, codes and the CRC-16 byte update for the Modbus RTU register master.
package mrm_pkg;

  // Command codes on the input word.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // Result kinds.
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Completion status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HEADER  = 2'd1;
  localparam logic [1:0] ST_CRC     = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Modbus function codes and frame constants.
  localparam logic [7:0]  FC_READ   = 8'h03;
  localparam logic [7:0]  FC_WRITE  = 8'h06;
  localparam logic [7:0]  READ_CNT  = 8'h01;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd1;
  localparam int CFG_DATA_W = 10;
  localparam logic [9:0] TIMEOUT_RESET = 10'd100;
  localparam logic [9:0] TICKS_MAX     = 10'h3FF;

  // Depth of the queue between the front and back parts.
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  reg_addr;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  status;
    logic [15:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic write;
    logic rx;
    logic tick;
  } item_class_t;

  typedef struct packed {
    item_class_t cls;
    logic [7:0]  reg_addr;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
  } q_entry_t;

  // One byte of the reflected CRC-16 update, eight shift steps.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/modbus_rtu_register_master_core.sv -----
// A start word passes through the queue into the serializer in the back part, which gives
// one request byte per cycle, eight in all, while no result word is stalled. A start holds
// the back part until its last request byte is loaded; a completion word is registered when
// the final response byte or a timing-out tick is popped. Words are accepted every cycle
// while the queue has room; a stalled result word holds the back part.
// Synchronous reset clears the control state, sets device_id 0, timeout 100.
module modbus_rtu_register_master_core #(
  parameter int QUEUE_DEPTH = mrm_pkg::Q_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mrm_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mrm_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mrm_pkg::*;

  logic [7:0] device_id;
  logic [9:0] timeout_ticks;
  logic       q_valid;
  logic       q_pop;
  q_entry_t   q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id     <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEVICE_ID: device_id     <= cfg_data[7:0];
        default:       timeout_ticks <= cfg_data[9:0];
      endcase
    end
  end

  mrm_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  mrm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .device_id     (device_id),
    .timeout_ticks (timeout_ticks),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_head        (q_head),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item)
  );

endmodule

// ----- design/mrm_front.sv -----
// Front part: accepts input words, classifies the command and queues them for the back part.
module mrm_front #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mrm_pkg::in_item_t in_item,
  output logic              q_valid,
  input  logic              q_pop,
  output mrm_pkg::q_entry_t q_head
);
  import mrm_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  q_entry_t entry_in;
  logic push;
  logic pop;

  always_comb begin
    entry_in = '0;
    entry_in.cls.start  = (in_item.cmd == CMD_READ) || (in_item.cmd == CMD_WRITE);
    entry_in.cls.write  = (in_item.cmd == CMD_WRITE);
    entry_in.cls.rx     = (in_item.cmd == CMD_RX);
    entry_in.cls.tick   = (in_item.cmd == CMD_TICK);
    entry_in.reg_addr    = in_item.reg_addr;
    entry_in.write_value = in_item.write_value;
    entry_in.rx_byte     = in_item.rx_byte;
  end

  assign in_ready = (count != CNT_W'(DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_pop;
  assign q_head   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/mrm_back.sv -----
// Back part: transaction state, request serializer, response checker and output register.
module mrm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         device_id,
  input  logic [9:0]         timeout_ticks,
  input  logic               q_valid,
  output logic               q_pop,
  input  mrm_pkg::q_entry_t  q_head,
  output logic               out_valid,
  input  logic               out_ready,
  output mrm_pkg::out_item_t out_item
);
  import mrm_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_READ  = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;

  logic [1:0]  phase;
  logic [3:0]  rx_count;
  logic [15:0] running_crc;
  logic [7:0]  crc_low;
  logic        header_ok;
  logic [15:0] data_word;
  logic [9:0]  elapsed;

  logic        sending;
  logic [2:0]  tx_idx;
  logic [15:0] tx_crc;
  logic        tx_write;
  logic [7:0]  tx_reg;
  logic [15:0] tx_val;
  logic [7:0]  tx_byte;

  logic        out_free;
  logic        out_load;
  logic [9:0]  elapsed_next;
  logic        header_ok_next;
  logic        is_read;
  logic [3:0]  crc_lo_idx;
  logic [3:0]  final_idx;
  logic [7:0]  b;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = q_valid && !sending && out_free;
  assign b        = q_head.rx_byte;
  assign is_read  = (phase == PH_READ);

  always_comb begin
    unique case (tx_idx)
      3'd0:    tx_byte = device_id;
      3'd1:    tx_byte = tx_write ? FC_WRITE : FC_READ;
      3'd2:    tx_byte = 8'h00;
      3'd3:    tx_byte = tx_reg;
      3'd4:    tx_byte = tx_write ? tx_val[15:8] : 8'h00;
      3'd5:    tx_byte = tx_write ? tx_val[7:0] : READ_CNT;
      3'd6:    tx_byte = tx_crc[7:0];
      default: tx_byte = tx_crc[15:8];
    endcase
  end

  always_comb begin
    elapsed_next = (elapsed != TICKS_MAX) ? elapsed + 10'd1 : elapsed;
    crc_lo_idx   = is_read ? 4'd5 : 4'd6;
    final_idx    = is_read ? 4'd6 : 4'd7;
    header_ok_next = header_ok;
    if (rx_count == 4'd0 && b != device_id) begin
      header_ok_next = 1'b0;
    end
    if (rx_count == 4'd1 && is_read && b != FC_READ) begin
      header_ok_next = 1'b0;
    end
    // A new result word is loaded by a request byte, a timeout or a final response byte.
    out_load = 1'b0;
    if (sending && out_free) begin
      out_load = 1'b1;
    end else if (q_pop && !q_head.cls.start && phase != PH_IDLE) begin
      if (q_head.cls.tick) begin
        out_load = (elapsed_next >= timeout_ticks);
      end else begin
        out_load = (rx_count == final_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      sending     <= 1'b0;
      out_valid   <= 1'b0;
      rx_count    <= '0;
      running_crc <= CRC_INIT;
      crc_low     <= '0;
      header_ok   <= 1'b1;
      data_word   <= '0;
      elapsed     <= '0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (sending && out_free) begin
        // Request bytes go out one per cycle while the output is free, the CRC running alongside.
        out_valid           <= 1'b1;
        out_item.kind       <= KIND_TX;
        out_item.tx_byte    <= tx_byte;
        out_item.last       <= (tx_idx == 3'd7);
        out_item.status     <= ST_OK;
        out_item.read_value <= '0;
        if (tx_idx < 3'd6) begin
          tx_crc <= crc_feed(tx_crc, tx_byte);
        end
        tx_idx <= tx_idx + 3'd1;
        if (tx_idx == 3'd7) begin
          sending <= 1'b0;
        end
      end else if (q_pop) begin
        if (q_head.cls.start) begin
          if (phase == PH_IDLE) begin
            tx_write    <= q_head.cls.write;
            tx_reg      <= q_head.reg_addr;
            tx_val      <= q_head.write_value;
            tx_idx      <= '0;
            tx_crc      <= CRC_INIT;
            sending     <= 1'b1;
            rx_count    <= '0;
            running_crc <= CRC_INIT;
            crc_low     <= '0;
            header_ok   <= 1'b1;
            data_word   <= '0;
            elapsed     <= '0;
            phase       <= q_head.cls.write ? PH_WRITE : PH_READ;
          end
        end else if (q_head.cls.tick) begin
          if (phase != PH_IDLE) begin
            elapsed <= elapsed_next;
            if (elapsed_next >= timeout_ticks) begin
              out_valid           <= 1'b1;
              out_item.kind       <= KIND_DONE;
              out_item.tx_byte    <= '0;
              out_item.last       <= 1'b1;
              out_item.status     <= ST_TIMEOUT;
              out_item.read_value <= '0;
              phase               <= PH_IDLE;
            end
          end
        end else if (phase != PH_IDLE) begin
          header_ok <= header_ok_next;
          if (is_read && rx_count == 4'd3) begin
            data_word <= {b, 8'h00};
          end
          if (is_read && rx_count == 4'd4) begin
            data_word <= {data_word[15:8], b};
          end
          if (rx_count < crc_lo_idx) begin
            running_crc <= crc_feed(running_crc, b);
          end else if (rx_count == crc_lo_idx) begin
            crc_low <= b;
          end
          rx_count <= rx_count + 4'd1;
          if (rx_count == final_idx) begin
            out_valid        <= 1'b1;
            out_item.kind    <= KIND_DONE;
            out_item.tx_byte <= '0;
            out_item.last    <= 1'b1;
            out_item.read_value <= '0;
            if (!header_ok_next) begin
              out_item.status <= ST_HEADER;
            end else if ({b, crc_low} != running_crc) begin
              out_item.status <= ST_CRC;
            end else begin
              out_item.status <= ST_OK;
              if (is_read) begin
                out_item.read_value <= data_word;
              end
            end
            phase <= PH_IDLE;
          end
        end
      end
    end
  end

endmodule

// ----- design/mrm_checker.sv -----
// Port-level checks on the result words of the register master, bound to the top level.
module mrm_port_checks (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input mrm_pkg::out_item_t out_item
);
  import mrm_pkg::*;

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result word changed while stalled");

  // Request bytes never carry status or read data.
  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_TX |-> out_item.status == ST_OK &&
      out_item.read_value == 16'h0000)
    else $error("request byte carries status or data");

  // A completion word always closes the transaction and sends no byte.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_DONE |-> out_item.last && out_item.tx_byte == 8'h00)
    else $error("completion word malformed");

  // Failed transactions return no data.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_DONE && out_item.status != ST_OK |->
      out_item.read_value == 16'h0000)
    else $error("failed completion returned data");

endmodule

bind modbus_rtu_register_master_core mrm_port_checks u_mrm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
